// File: hw/rtl/obtt_pkg.sv
`timescale 1ns / 1ps
package obtt_pkg;

  localparam int DefaultOrderSlots = 128;
  localparam int InDataW = 96;
  localparam int InUserW = 3;
  localparam int OutDataW = 168;

  localparam logic [1:0] KIND_NEW = 2'd0;
  localparam logic [1:0] KIND_MODIFY = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_en;
    logic apply;
    logic finish;
    logic load_out;
  } obtt_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rescan;
    logic out_busy;
  } obtt_status_t;

endpackage

// File: hw/rtl/obtt_ctrl.sv
`timescale 1ns / 1ps
module obtt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  m_tready,
  input  obtt_pkg::obtt_status_t status,
  output obtt_pkg::obtt_cmd_t    cmd
);
  import obtt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_RESCAN = 3'd4;
  localparam logic [2:0] ST_DRAIN2 = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;
  localparam logic [2:0] ST_RESULT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_APPLY;
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.rescan) begin
          cmd.scan_start = 1'b1;
          state_next = ST_RESCAN;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN2;
      end
      ST_DRAIN2: state_next = ST_FINISH;
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_busy || m_tready) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/obtt_datapath.sv
`timescale 1ns / 1ps
module obtt_datapath #(
  parameter int ORDER_SLOTS = obtt_pkg::DefaultOrderSlots,
  parameter int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [obtt_pkg::InDataW-1:0]  s_tdata,
  input  logic [obtt_pkg::InUserW-1:0]  s_tuser,
  input  logic                          m_tready,
  input  obtt_pkg::obtt_cmd_t           cmd,
  output obtt_pkg::obtt_status_t        status,
  output logic                          m_tvalid,
  output logic [obtt_pkg::OutDataW-1:0] m_tdata
);
  import obtt_pkg::*;

  logic                   mem_side  [ORDER_SLOTS];
  logic [31:0]            mem_order [ORDER_SLOTS];
  logic [31:0]            mem_price [ORDER_SLOTS];
  logic [31:0]            mem_qty   [ORDER_SLOTS];
  logic [31:0]            mem_arr   [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] valid;

  logic [1:0]  in_kind;
  logic        in_buy;
  logic [31:0] in_id;
  logic [31:0] in_price;
  logic [31:0] in_qty;

  logic [IDX_W-1:0] cnt;
  logic             rd_act;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_side;
  logic [31:0]      rd_order;
  logic [31:0]      rd_price;
  logic [31:0]      rd_qty;
  logic [31:0]      rd_arr;

  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [31:0]      best_price;
  logic [31:0]      best_qty;
  logic [31:0]      best_arr;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_price;
  logic [31:0]      hit_qty;
  logic [31:0]      hit_arr;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic        bid_valid, ask_valid;
  logic [31:0] bid_price, bid_qty, ask_price, ask_qty;
  logic [31:0] arrival_counter;
  logic [31:0] update_counter;
  logic        changed;
  logic        full;

  logic ent, better_rd, take_best, take_hit, take_free;
  logic is_ins, is_rem, full_rem, ins_top;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [31:0]      mem_wqty;
  logic [31:0]      mem_warr;
  logic [31:0]      part_qty;

  assign ent = rd_act && valid[rd_idx] && (rd_side == in_buy);
  assign better_rd = in_buy ? (rd_price > best_price) : (rd_price < best_price);
  assign take_best = ent && (!best_found ||
                     ((rd_price == best_price) ? (rd_arr < best_arr) : better_rd));
  assign take_hit = ent && (rd_order == in_id) && (!hit_found || (rd_arr > hit_arr));
  assign take_free = rd_act && !valid[rd_idx] && !free_found;

  assign is_ins = (in_kind == KIND_NEW) || (in_kind == KIND_MODIFY);
  assign is_rem = (in_kind == KIND_REMOVE);
  assign full_rem = hit_qty <= in_qty;
  assign ins_top = !best_found ||
                   (in_buy ? (in_price > best_price) : (in_price < best_price));
  assign part_qty = hit_qty - in_qty;

  assign status.scan_last = (cnt == IDX_W'(ORDER_SLOTS - 1));
  assign status.rescan = is_rem && hit_found && full_rem && (hit_price == best_price);
  assign status.out_busy = m_tvalid;

  assign mem_we = cmd.apply && ((is_ins && free_found) ||
                                (is_rem && hit_found && !full_rem));
  assign mem_wa = is_ins ? free_idx : hit_idx;
  assign mem_wqty = is_ins ? in_qty : part_qty;
  assign mem_warr = is_ins ? arrival_counter : hit_arr;

  // slot table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_side[mem_wa]  <= in_buy;
      mem_order[mem_wa] <= in_id;
      mem_price[mem_wa] <= is_ins ? in_price : hit_price;
      mem_qty[mem_wa]   <= mem_wqty;
      mem_arr[mem_wa]   <= mem_warr;
    end
    rd_side  <= mem_side[cnt];
    rd_order <= mem_order[cnt];
    rd_price <= mem_price[cnt];
    rd_qty   <= mem_qty[cnt];
    rd_arr   <= mem_arr[cnt];
    rd_idx   <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_act <= 1'b0;
      cnt <= '0;
    end else begin
      rd_act <= cmd.scan_en;
      if (cmd.capture || cmd.scan_start) cnt <= '0;
      else if (cmd.scan_en && !status.scan_last) cnt <= cnt + 1'b1;
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.capture) begin
      best_found <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_start) begin
      best_found <= 1'b0;
    end else begin
      if (take_best) begin
        best_found <= 1'b1;
        best_idx <= rd_idx;
        best_price <= rd_price;
        best_qty <= rd_qty;
        best_arr <= rd_arr;
      end
      if (take_hit) begin
        hit_found <= 1'b1;
        hit_idx <= rd_idx;
        hit_price <= rd_price;
        hit_qty <= rd_qty;
        hit_arr <= rd_arr;
      end
      if (take_free) begin
        free_found <= 1'b1;
        free_idx <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_id <= s_tdata[31:0];
      in_price <= s_tdata[63:32];
      in_qty <= s_tdata[95:64];
      in_kind <= s_tuser[1:0];
      in_buy <= s_tuser[2];
    end
  end

  // heads, counters and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      bid_valid <= 1'b0;
      bid_price <= '0;
      bid_qty <= '0;
      ask_valid <= 1'b0;
      ask_price <= '0;
      ask_qty <= '0;
      arrival_counter <= '0;
      update_counter <= '0;
      changed <= 1'b0;
      full <= 1'b0;
    end else if (cmd.capture) begin
      changed <= 1'b0;
      full <= 1'b0;
    end else if (cmd.apply) begin
      if (is_ins) begin
        if (!free_found) begin
          full <= 1'b1;
        end else begin
          valid[free_idx] <= 1'b1;
          arrival_counter <= arrival_counter + 32'd1;
          if (ins_top) begin
            update_counter <= update_counter + 32'd1;
            changed <= 1'b1;
            if (in_buy) begin
              bid_valid <= 1'b1;
              bid_price <= in_price;
              bid_qty <= in_qty;
            end else begin
              ask_valid <= 1'b1;
              ask_price <= in_price;
              ask_qty <= in_qty;
            end
          end
        end
      end else if (is_rem && hit_found) begin
        if (full_rem) begin
          valid[hit_idx] <= 1'b0;
        end else if (hit_idx == best_idx) begin
          update_counter <= update_counter + 32'd1;
          changed <= 1'b1;
          if (in_buy) begin
            bid_valid <= 1'b1;
            bid_price <= hit_price;
            bid_qty <= part_qty;
          end else begin
            ask_valid <= 1'b1;
            ask_price <= hit_price;
            ask_qty <= part_qty;
          end
        end
      end
    end else if (cmd.finish) begin
      if (!best_found) begin
        if (in_buy) begin
          bid_valid <= 1'b0;
          bid_price <= '0;
          bid_qty <= '0;
        end else begin
          ask_valid <= 1'b0;
          ask_price <= '0;
          ask_qty <= '0;
        end
      end else if (best_price != hit_price) begin
        update_counter <= update_counter + 32'd1;
        changed <= 1'b1;
        if (in_buy) begin
          bid_valid <= 1'b1;
          bid_price <= best_price;
          bid_qty <= best_qty;
        end else begin
          ask_valid <= 1'b1;
          ask_price <= best_price;
          ask_qty <= best_qty;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'd0, full, update_counter, changed, ask_valid, ask_qty, ask_price,
                  bid_valid, bid_qty, bid_price};
    end
  end

endmodule

// File: hw/rtl/order_book_top_tracker_top.sv
`timescale 1ns / 1ps
// top-of-book tracker over a table of resting orders
// input beat: tuser = kind, is_buy; tdata = order_id, price, quantity
// every input beat gives exactly one output beat with both heads, a change
// flag, the wrapping update count and a flag for an insert dropped when full
// a beat scans the whole slot table once through one memory read port,
// one slot per cycle; a full removal of a head-price order scans it twice
// a new beat is taken only after the last one is through; the next beat is
// taken while a finished result still waits in the output register
// reset empties the book, clears heads and counters; no clearing pass needed
// a stalled receiver holds the result; the block then finishes at most one
// more beat and waits with s_tready low
module order_book_top_tracker_top #(
  parameter int ORDER_SLOTS = obtt_pkg::DefaultOrderSlots
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // order_id, price, quantity
  input  logic [obtt_pkg::InDataW-1:0]  s_tdata,
  // kind, is_buy
  input  logic [obtt_pkg::InUserW-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // bid_price, bid_qty, bid_valid, ask_price, ask_qty, ask_valid,
  // top_changed, update_count, book_full
  output logic [obtt_pkg::OutDataW-1:0] m_tdata
);
  import obtt_pkg::*;

  localparam int IdxW = $clog2(ORDER_SLOTS);

  obtt_cmd_t    cmd;
  obtt_status_t status;

  obtt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tready(m_tready), .status(status), .cmd(cmd)
  );

  obtt_datapath #(.ORDER_SLOTS(ORDER_SLOTS), .IDX_W(IdxW)) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tready(m_tready), .cmd(cmd), .status(status),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata)
  );

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[163] |-> !m_tdata[130])
    else $error("dropped insert reported a top change");

  a_empty_bid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[64] |-> m_tdata[63:0] == 64'd0)
    else $error("empty bid side with nonzero fields");

  a_empty_ask_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[129] |-> m_tdata[128:65] == 64'd0)
    else $error("empty ask side with nonzero fields");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !m_tvalid || m_tready)
    else $error("output overwritten while stalled");

endmodule

// File: test/tb_order_book_top_tracker_top.sv
`timescale 1ns / 1ps
module tb_order_book_top_tracker_top;
  import obtt_pkg::*;

  localparam int Slots = DefaultOrderSlots;
  localparam logic [1:0] KindBad = 2'd3;

  typedef struct {
    logic [31:0] bid_price, bid_qty, ask_price, ask_qty, update_count;
    logic        bid_valid, ask_valid, top_changed, book_full;
  } tob_t;

  class book_scoreboard;
    bit          live[Slots];
    bit          side_of[Slots];
    bit [31:0]   id_of[Slots], price_of[Slots], qty_of[Slots], stamp_of[Slots];
    bit [31:0]   stamp_next, upd_cnt;
    bit          hv[2];
    bit [31:0]   hp[2], hq[2];
    tob_t        pending[$];
    int          errors, checked, fulls, changes;

    function int best_slot(bit s);
      int b;
      b = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!live[i] || side_of[i] != s) continue;
        if (b < 0) b = i;
        else if (price_of[i] == price_of[b]) begin
          if (stamp_of[i] < stamp_of[b]) b = i;
        end else if (s ? price_of[i] > price_of[b] : price_of[i] < price_of[b]) b = i;
      end
      return b;
    endfunction

    function int newest_slot(bit s, bit [31:0] id);
      int h;
      h = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!live[i] || side_of[i] != s || id_of[i] != id) continue;
        if (h < 0 || stamp_of[i] > stamp_of[h]) h = i;
      end
      return h;
    endfunction

    function void note_update(logic [1:0] kind, bit s, bit [31:0] id, bit [31:0] pr,
                              bit [31:0] q);
      tob_t e;
      bit chg, full;
      int fr, b, m, nb;
      bit [31:0] gone;
      chg = 0;
      full = 0;
      if (kind == KIND_NEW || kind == KIND_MODIFY) begin
        fr = -1;
        for (int i = 0; i < Slots; i++)
          if (!live[i] && fr < 0) fr = i;
        if (fr < 0) full = 1;
        else begin
          b = best_slot(s);
          if (b < 0 || (s ? pr > price_of[b] : pr < price_of[b])) begin
            hv[s] = 1; hp[s] = pr; hq[s] = q; upd_cnt++; chg = 1;
          end
          live[fr] = 1; side_of[fr] = s; id_of[fr] = id; price_of[fr] = pr;
          qty_of[fr] = q; stamp_of[fr] = stamp_next; stamp_next++;
        end
      end else if (kind == KIND_REMOVE) begin
        m = newest_slot(s, id);
        if (m >= 0) begin
          b = best_slot(s);
          if (qty_of[m] <= q) begin
            gone = price_of[m];
            live[m] = 0;
            if (gone == price_of[b]) begin
              nb = best_slot(s);
              if (nb < 0) begin
                hv[s] = 0; hp[s] = 0; hq[s] = 0;
              end else if (price_of[nb] != gone) begin
                hv[s] = 1; hp[s] = price_of[nb]; hq[s] = qty_of[nb]; upd_cnt++; chg = 1;
              end
            end
          end else begin
            qty_of[m] = qty_of[m] - q;
            if (m == b) begin
              hv[s] = 1; hp[s] = price_of[m]; hq[s] = qty_of[m]; upd_cnt++; chg = 1;
            end
          end
        end
      end
      e.bid_price = hp[1]; e.bid_qty = hq[1]; e.bid_valid = hv[1];
      e.ask_price = hp[0]; e.ask_qty = hq[0]; e.ask_valid = hv[0];
      e.top_changed = chg; e.update_count = upd_cnt; e.book_full = full;
      fulls += full;
      changes += chg;
      pending.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] x, logic [31:0] a);
      if (a !== x) begin
        $error("%s expected %0h got %0h", name, x, a);
        errors++;
      end
    endfunction

    function void check_top(logic [OutDataW-1:0] d);
      tob_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("output beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("bid_price", e.bid_price, d[31:0]);
      cmp("bid_qty", e.bid_qty, d[63:32]);
      cmp("bid_valid", e.bid_valid, d[64]);
      cmp("ask_price", e.ask_price, d[96:65]);
      cmp("ask_qty", e.ask_qty, d[128:97]);
      cmp("ask_valid", e.ask_valid, d[129]);
      cmp("top_changed", e.top_changed, d[130]);
      cmp("update_count", e.update_count, d[162:131]);
      cmp("book_full", e.book_full, d[163]);
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic [OutDataW-1:0] m_tdata;

  book_scoreboard sb = new();
  int sent;
  bit quiet;

  order_book_top_tracker_top uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[order_book_top_tracker_top] ERROR");
    $finish;
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_top(m_tdata);

  // receiver side: random stalls plus one long hold-off
  initial begin
    bit held;
    held = 0;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && sent >= 400) begin
        held = 1;
        m_tready <= 0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1;
      repeat ($urandom_range(0, 30)) @(posedge clk);
    end
  end

  task automatic send_update(logic [1:0] kind, bit s, bit [31:0] id, bit [31:0] pr,
                             bit [31:0] q);
    s_tvalid <= 1;
    s_tuser <= {s, kind};
    s_tdata <= {q, pr, id};
    do @(posedge clk); while (!s_tready);
    sb.note_update(kind, s, id, pr, q);
    sent++;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_remove_of_live(bit partial);
    int k;
    k = -1;
    for (int t = 0; t < 8 && k < 0; t++) begin
      k = $urandom_range(0, Slots - 1);
      if (!sb.live[k]) k = -1;
    end
    if (k < 0)
      send_update(KIND_REMOVE, 1'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom,
                  $urandom);
    else if (partial && sb.qty_of[k] > 1)
      send_update(KIND_REMOVE, sb.side_of[k], sb.id_of[k], $urandom,
                  $urandom_range(1, sb.qty_of[k] - 1));
    else
      send_update(KIND_REMOVE, sb.side_of[k], sb.id_of[k], $urandom,
                  sb.qty_of[k] + $urandom_range(0, 3) > sb.qty_of[k] ?
                  sb.qty_of[k] + $urandom_range(0, 3) : 32'hffffffff);
  endtask

  function automatic bit [31:0] pick_price();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return $urandom;
      default: return 1000 + $urandom_range(0, 12);
    endcase
  endfunction

  initial begin
    int fill;
    rst = 1;
    s_tvalid = 0;
    s_tuser = '0;
    s_tdata = '0;
    sent = 0;
    quiet = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send_update(KIND_REMOVE, 1, 7, 0, 5);
    send_update(KIND_NEW, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_update(KIND_NEW, 0, 0, 0, 0);
    send_update(KIND_NEW, 1, 1, 100, 10);
    send_update(KIND_MODIFY, 1, 2, 100, 20);
    send_update(KIND_NEW, 0, 3, 50, 30);
    send_update(KIND_NEW, 0, 4, 40, 40);
    send_update(KIND_NEW, 0, 5, 40, 45);
    send_update(KIND_REMOVE, 0, 4, 0, 15);
    send_update(KIND_REMOVE, 0, 4, 0, 25);
    send_update(KIND_REMOVE, 0, 5, 0, 45);
    send_update(KIND_REMOVE, 1, 32'hffffffff, 0, 32'hfffffffe);
    send_update(KIND_REMOVE, 1, 32'hffffffff, 0, 32'hffffffff);
    send_update(KIND_NEW, 1, 9, 100, 5);
    send_update(KIND_NEW, 1, 9, 100, 6);
    send_update(KIND_REMOVE, 1, 1, 0, 10);
    send_update(KIND_REMOVE, 1, 9, 0, 6);
    send_update(KIND_REMOVE, 1, 2, 0, 20);
    send_update(KIND_REMOVE, 1, 9, 0, 5);
    send_update(KIND_REMOVE, 0, 0, 0, 0);
    send_update(KIND_REMOVE, 0, 3, 0, 100);
    send_update(KIND_NEW, 0, 1, 32'h5555aaaa, 32'haaaa5555);
    send_update(KIND_NEW, 1, 2, 32'haaaa5555, 32'h5555aaaa);
    send_update(KIND_REMOVE, 0, 1, 0, 32'hffffffff);
    send_update(KindBad, 1, 2, 0, 32'hffffffff);

    // random, alternating fill and drain phases
    fill = 1;
    while (sent < 1900) begin
      int r;
      if (sent % 150 == 0) fill = !fill;
      quiet = sent > 1600;
      r = $urandom_range(0, 99);
      if (r < 2)
        send_update(KindBad, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      else if (r < 5)
        send_update(KIND_REMOVE, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      else if (r < (fill ? 80 : 35))
        send_update($urandom_range(0, 1) ? KIND_NEW : KIND_MODIFY,
                    1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15),
                    pick_price(),
                    $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 50));
      else
        send_remove_of_live(1'($urandom_range(0, 1)));
    end
    s_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * Slots + 20) @(posedge clk);
    $display("checked %0d top-of-book beats from %0d updates", sb.checked, sent);
    $display("%0d head changes, %0d inserts dropped on a full book", sb.changes, sb.fulls);
    if (sb.errors == 0) begin
      $display("[order_book_top_tracker_top] OK");
    end else begin
      $display("[order_book_top_tracker_top] ERROR");
    end
    $finish;
  end
endmodule
